// ===== src/sfr_pkg.sv =====
// ============================================================================
// Sensor frame receiver package
// Constants, state encoding and controller/datapath interface types shared
// by the modules of the particulate sensor frame receiver.
// ============================================================================
package sfr_pkg;

    // Frame geometry.
    localparam int NUM_WORDS    = 17;
    localparam int FRAME_LEN    = 2 * NUM_WORDS + 6;
    localparam int BYTE_CNT_W   = $clog2(FRAME_LEN);
    localparam int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Field widths of one word.
    localparam int RX_W         = 8;
    localparam int WORD_W       = 16;
    localparam int INDEX_W      = 5;

    // Header bytes and expected length field.
    localparam logic [RX_W-1:0]       HDR_HI       = 8'h42;
    localparam logic [RX_W-1:0]       HDR_LO       = 8'h4D;
    localparam logic [WORD_W-1:0]     EXPECTED_LEN = WORD_W'(2 * NUM_WORDS + 2);
    localparam logic [WORD_W-1:0]     HDR_SUM      = WORD_W'(8'h42) + WORD_W'(8'h4D);

    // Frame byte positions of interest.
    localparam logic [BYTE_CNT_W-1:0] POS_FIRST    = BYTE_CNT_W'(2);
    localparam logic [BYTE_CNT_W-1:0] POS_LEN_LO   = BYTE_CNT_W'(3);
    localparam logic [BYTE_CNT_W-1:0] POS_WORD0_LO = BYTE_CNT_W'(5);
    localparam logic [BYTE_CNT_W-1:0] POS_SUM_HI   = BYTE_CNT_W'(FRAME_LEN - 2);
    localparam logic [BYTE_CNT_W-1:0] POS_LAST     = BYTE_CNT_W'(FRAME_LEN - 1);
    localparam logic [ADDR_W-1:0]     LAST_WORD    = ADDR_W'(NUM_WORDS - 1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_BODY,
        ST_READ,
        ST_EMIT,
        ST_ERR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hunt_byte;
        logic body_byte;
        logic rd_word;
        logic emit_word;
        logic emit_err;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_start;
        logic last_byte;
        logic frame_ok;
        logic out_free;
        logic last_word;
    } t_dp_status;

endpackage

// ===== src/sensor_frame_receiver.sv =====
// ============================================================================
// Sensor frame receiver
// Parses 40-byte particulate sensor frames from a serial byte stream and
// delivers the 17 measurement words, or a single error word.
// ============================================================================
// Received bytes are taken while the block hunts for the 0x42 0x4D header
// or collects a frame body. On the final byte the sum of bytes 0 to 37 is
// checked against the trailing checksum, and the length field against 36.
// A good frame is then drained from the word store one word at a time (a
// registered store read, then a load of the output register), waiting on
// any output stall, while the byte input is stalled. A bad frame gives one
// error word with status 1 once the output register is free. No resync is
// made inside a frame: header bytes there count as data.
module sensor_frame_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sfr_pkg::RX_W-1:0]     i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sfr_pkg::INDEX_W-1:0]  o_word_index,
    output logic [sfr_pkg::WORD_W-1:0]   o_word_value,
    output logic                         o_frame_status,
    output logic                         o_last_of_frame
);

    sfr_pkg::t_dp_cmd    cmd;
    sfr_pkg::t_dp_status status;

    // Frame sequencing.
    sfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Frame tracking, word store and output register.
    sfr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_word_index    (o_word_index),
        .o_word_value    (o_word_value),
        .o_frame_status  (o_frame_status),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== src/sfr_ctrl.sv =====
// ============================================================================
// Sensor frame receiver controller
// Sequences the header hunt, the frame body collection and the drain of
// the stored measurement words or of the error word.
// ============================================================================
module sfr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sfr_pkg::t_dp_status i_status,
    output logic                o_stall,
    output sfr_pkg::t_dp_cmd    o_cmd
);

    sfr_pkg::t_state r_state;
    sfr_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfr_pkg::ST_HUNT: begin
                if (i_valid && i_status.frame_start) begin
                    n_state = sfr_pkg::ST_BODY;
                end
            end
            sfr_pkg::ST_BODY: begin
                if (i_valid && i_status.last_byte) begin
                    n_state = i_status.frame_ok ? sfr_pkg::ST_READ : sfr_pkg::ST_ERR;
                end
            end
            sfr_pkg::ST_READ: begin
                n_state = sfr_pkg::ST_EMIT;
            end
            sfr_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_word ? sfr_pkg::ST_HUNT : sfr_pkg::ST_READ;
                end
            end
            sfr_pkg::ST_ERR: begin
                if (i_status.out_free) begin
                    n_state = sfr_pkg::ST_HUNT;
                end
            end
            default: begin
                n_state = sfr_pkg::ST_HUNT;
            end
        endcase
    end

    // Outputs: bytes are taken only while hunting or collecting a frame.
    always_comb begin
        o_stall = 1'b1;
        o_cmd   = '0;
        unique case (r_state)
            sfr_pkg::ST_HUNT: begin
                o_stall         = 1'b0;
                o_cmd.hunt_byte = i_valid;
            end
            sfr_pkg::ST_BODY: begin
                o_stall         = 1'b0;
                o_cmd.body_byte = i_valid;
            end
            sfr_pkg::ST_READ: begin
                o_cmd.rd_word = 1'b1;
            end
            sfr_pkg::ST_EMIT: begin
                o_cmd.emit_word = i_status.out_free;
            end
            sfr_pkg::ST_ERR: begin
                o_cmd.emit_err = i_status.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/sfr_datapath.sv =====
// ============================================================================
// Sensor frame receiver datapath
// Header detection, byte position and checksum tracking, the word store and
// the output register for result words.
// ============================================================================
module sfr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [sfr_pkg::RX_W-1:0]            i_rx_byte,
    input  logic                                i_stall,
    input  sfr_pkg::t_dp_cmd                    i_cmd,
    output sfr_pkg::t_dp_status                 o_status,
    output logic                                o_valid,
    output logic [sfr_pkg::INDEX_W-1:0]         o_word_index,
    output logic [sfr_pkg::WORD_W-1:0]          o_word_value,
    output logic                                o_frame_status,
    output logic                                o_last_of_frame
);

    logic                              r_header_seen;
    logic [sfr_pkg::BYTE_CNT_W-1:0]    r_byte_cnt;
    logic [sfr_pkg::WORD_W-1:0]        r_sum;
    logic [sfr_pkg::RX_W-1:0]          r_pending_high;
    logic [sfr_pkg::WORD_W-1:0]        r_length;
    logic [sfr_pkg::WORD_W-1:0]        r_mem [sfr_pkg::NUM_WORDS];
    logic [sfr_pkg::ADDR_W-1:0]        r_rd_idx;
    logic [sfr_pkg::WORD_W-1:0]        r_rd_data;
    logic                              r_valid;
    logic [sfr_pkg::INDEX_W-1:0]       r_index;
    logic [sfr_pkg::WORD_W-1:0]        r_value;
    logic                              r_status;
    logic                              r_last;

    logic [sfr_pkg::WORD_W-1:0]        pair;
    logic [sfr_pkg::BYTE_CNT_W-1:0]    word_off;
    logic                              wr_en;
    logic                              frame_start;

    // Big-endian pair assembled from the held high byte and this byte.
    assign pair        = {r_pending_high, i_rx_byte};
    assign frame_start = (i_rx_byte == sfr_pkg::HDR_LO) && r_header_seen;
    assign word_off    = r_byte_cnt - sfr_pkg::POS_WORD0_LO;

    // A measurement word completes on every odd position from the first word
    // up to, but not including, the checksum.
    assign wr_en = i_cmd.body_byte && r_byte_cnt[0]
                   && (r_byte_cnt != sfr_pkg::POS_LEN_LO)
                   && (r_byte_cnt != sfr_pkg::POS_LAST);

    // Status toward the controller.
    always_comb begin
        o_status.frame_start = frame_start;
        o_status.last_byte   = (r_byte_cnt == sfr_pkg::POS_LAST);
        o_status.frame_ok    = (pair == r_sum) && (r_length == sfr_pkg::EXPECTED_LEN);
        o_status.out_free    = !r_valid || !i_stall;
        o_status.last_word   = (r_rd_idx == sfr_pkg::LAST_WORD);
    end

    // Hunt flag, byte position and running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_seen <= 1'b0;
            r_byte_cnt    <= sfr_pkg::POS_FIRST;
            r_sum         <= '0;
        end else if (i_cmd.hunt_byte) begin
            r_header_seen <= (i_rx_byte == sfr_pkg::HDR_HI);
            if (frame_start) begin
                r_byte_cnt <= sfr_pkg::POS_FIRST;
                r_sum      <= sfr_pkg::HDR_SUM;
            end
        end else if (i_cmd.body_byte) begin
            if (r_byte_cnt < sfr_pkg::POS_SUM_HI) begin
                r_sum <= r_sum + sfr_pkg::WORD_W'(i_rx_byte);
            end
            if (r_byte_cnt == sfr_pkg::POS_LAST) begin
                r_byte_cnt <= sfr_pkg::POS_FIRST;
            end else begin
                r_byte_cnt <= r_byte_cnt + sfr_pkg::BYTE_CNT_W'(1);
            end
        end
    end

    // Pending high byte and length field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_high <= '0;
            r_length       <= '0;
        end else if (i_cmd.body_byte) begin
            if (!r_byte_cnt[0]) begin
                r_pending_high <= i_rx_byte;
            end else if (r_byte_cnt == sfr_pkg::POS_LEN_LO) begin
                r_length <= pair;
            end
        end
    end

    // Word store: written while collecting, read once per word on drain.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[word_off[sfr_pkg::ADDR_W:1]] <= pair;
        end
        if (i_cmd.rd_word) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Drain index, cleared at the start of every frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.hunt_byte && frame_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.emit_word && (r_rd_idx != sfr_pkg::LAST_WORD)) begin
            r_rd_idx <= r_rd_idx + sfr_pkg::ADDR_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_word || i_cmd.emit_err) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_word) begin
            r_index  <= sfr_pkg::INDEX_W'(r_rd_idx);
            r_value  <= r_rd_data;
            r_status <= 1'b0;
            r_last   <= (r_rd_idx == sfr_pkg::LAST_WORD);
        end else if (i_cmd.emit_err) begin
            r_index  <= '0;
            r_value  <= '0;
            r_status <= 1'b1;
            r_last   <= 1'b1;
        end
    end

    assign o_valid         = r_valid;
    assign o_word_index    = r_index;
    assign o_word_value    = r_value;
    assign o_frame_status  = r_status;
    assign o_last_of_frame = r_last;

    // An error word is a single zero word that closes the frame.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> (r_last && (r_value == '0) && (r_index == '0)))
        else $error("error word has wrong shape");

    // The byte position never leaves the frame body range.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_cnt >= sfr_pkg::POS_FIRST) && (r_byte_cnt <= sfr_pkg::POS_LAST))
        else $error("byte position out of range");

    // A good word is marked last exactly when it is the final word.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_status) |->
        (r_last == (r_index == sfr_pkg::INDEX_W'(sfr_pkg::NUM_WORDS - 1))))
        else $error("last marker does not match word index");

    // A new word is never loaded while the held word is stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !(i_cmd.emit_word || i_cmd.emit_err))
        else $error("output register overwritten while stalled");

endmodule
